@@ rtl/assert_macros.svh @@
// Assertion macros included by the plotter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLIES(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("assertion failed: label");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("assertion failed: label");

`endif

@@ rtl/g8pp_pkg.sv @@
// Package of the glyph plotter: payload types, register codes and the font table.
package g8pp_pkg;

   localparam int GLYPH_COUNT_DEFAULT = 128;
   localparam int GLYPH_SIZE = 8;
   localparam int FONT_ENTRIES = 128;
   localparam int CODE_WIDTH = 7;
   localparam int ROW_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEST_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEST_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_PITCH = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_BASE = 2'd3;

   localparam logic [12:0] DEST_WIDTH_RESET = 13'd320;
   localparam logic [12:0] DEST_HEIGHT_RESET = 13'd200;
   localparam logic [13:0] LINE_PITCH_RESET = 14'd320;
   localparam logic [31:0] FRAME_BASE_RESET = 32'd0;

   typedef struct packed {
      logic [6:0] char_code;
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic [7:0] ink;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] pixel_address;
      logic [7:0] pixel_value;
      logic is_write;
      logic last_of_glyph;
   } rsp_payload_type;

   typedef logic [7:0] font_row_type;

   localparam font_row_type FONT_ROM [FONT_ENTRIES][GLYPH_SIZE] = '{
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h18,'h3C,'h3C,'h18,'h18,'h00,'h18,'h00},
      '{'h36,'h36,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h36,'h36,'h7F,'h36,'h7F,'h36,'h36,'h00},
      '{'h0C,'h3E,'h03,'h1E,'h30,'h1F,'h0C,'h00},
      '{'h00,'h63,'h33,'h18,'h0C,'h66,'h63,'h00},
      '{'h1C,'h36,'h1C,'h6E,'h3B,'h33,'h6E,'h00},
      '{'h06,'h06,'h03,'h00,'h00,'h00,'h00,'h00},
      '{'h18,'h0C,'h06,'h06,'h06,'h0C,'h18,'h00},
      '{'h06,'h0C,'h18,'h18,'h18,'h0C,'h06,'h00},
      '{'h00,'h66,'h3C,'hFF,'h3C,'h66,'h00,'h00},
      '{'h00,'h0C,'h0C,'h3F,'h0C,'h0C,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h0C,'h0C,'h06},
      '{'h00,'h00,'h00,'h3F,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h0C,'h0C,'h00},
      '{'h60,'h30,'h18,'h0C,'h06,'h03,'h01,'h00},
      '{'h3E,'h63,'h73,'h7B,'h6F,'h67,'h3E,'h00},
      '{'h0C,'h0E,'h0C,'h0C,'h0C,'h0C,'h3F,'h00},
      '{'h1E,'h33,'h30,'h1C,'h06,'h33,'h3F,'h00},
      '{'h1E,'h33,'h30,'h1C,'h30,'h33,'h1E,'h00},
      '{'h38,'h3C,'h36,'h33,'h7F,'h30,'h78,'h00},
      '{'h3F,'h03,'h1F,'h30,'h30,'h33,'h1E,'h00},
      '{'h1C,'h06,'h03,'h1F,'h33,'h33,'h1E,'h00},
      '{'h3F,'h33,'h30,'h18,'h0C,'h0C,'h0C,'h00},
      '{'h1E,'h33,'h33,'h1E,'h33,'h33,'h1E,'h00},
      '{'h1E,'h33,'h33,'h3E,'h30,'h18,'h0E,'h00},
      '{'h00,'h0C,'h0C,'h00,'h00,'h0C,'h0C,'h00},
      '{'h00,'h0C,'h0C,'h00,'h00,'h0C,'h0C,'h06},
      '{'h18,'h0C,'h06,'h03,'h06,'h0C,'h18,'h00},
      '{'h00,'h00,'h3F,'h00,'h00,'h3F,'h00,'h00},
      '{'h06,'h0C,'h18,'h30,'h18,'h0C,'h06,'h00},
      '{'h1E,'h33,'h30,'h18,'h0C,'h00,'h0C,'h00},
      '{'h3E,'h63,'h7B,'h7B,'h7B,'h03,'h1E,'h00},
      '{'h0C,'h1E,'h33,'h33,'h3F,'h33,'h33,'h00},
      '{'h3F,'h66,'h66,'h3E,'h66,'h66,'h3F,'h00},
      '{'h3C,'h66,'h03,'h03,'h03,'h66,'h3C,'h00},
      '{'h1F,'h36,'h66,'h66,'h66,'h36,'h1F,'h00},
      '{'h7F,'h46,'h16,'h1E,'h16,'h46,'h7F,'h00},
      '{'h7F,'h46,'h16,'h1E,'h16,'h06,'h0F,'h00},
      '{'h3C,'h66,'h03,'h03,'h73,'h66,'h7C,'h00},
      '{'h33,'h33,'h33,'h3F,'h33,'h33,'h33,'h00},
      '{'h1E,'h0C,'h0C,'h0C,'h0C,'h0C,'h1E,'h00},
      '{'h78,'h30,'h30,'h30,'h33,'h33,'h1E,'h00},
      '{'h67,'h66,'h36,'h1E,'h36,'h66,'h67,'h00},
      '{'h0F,'h06,'h06,'h06,'h46,'h66,'h7F,'h00},
      '{'h63,'h77,'h7F,'h7F,'h6B,'h63,'h63,'h00},
      '{'h63,'h67,'h6F,'h7B,'h73,'h63,'h63,'h00},
      '{'h1C,'h36,'h63,'h63,'h63,'h36,'h1C,'h00},
      '{'h3F,'h66,'h66,'h3E,'h06,'h06,'h0F,'h00},
      '{'h1E,'h33,'h33,'h33,'h3B,'h1E,'h38,'h00},
      '{'h3F,'h66,'h66,'h3E,'h36,'h66,'h67,'h00},
      '{'h1E,'h33,'h07,'h0E,'h38,'h33,'h1E,'h00},
      '{'h3F,'h2D,'h0C,'h0C,'h0C,'h0C,'h1E,'h00},
      '{'h33,'h33,'h33,'h33,'h33,'h33,'h3F,'h00},
      '{'h33,'h33,'h33,'h33,'h33,'h1E,'h0C,'h00},
      '{'h63,'h63,'h63,'h6B,'h7F,'h77,'h63,'h00},
      '{'h63,'h63,'h36,'h1C,'h1C,'h36,'h63,'h00},
      '{'h33,'h33,'h33,'h1E,'h0C,'h0C,'h1E,'h00},
      '{'h7F,'h63,'h31,'h18,'h4C,'h66,'h7F,'h00},
      '{'h1E,'h06,'h06,'h06,'h06,'h06,'h1E,'h00},
      '{'h03,'h06,'h0C,'h18,'h30,'h60,'h40,'h00},
      '{'h1E,'h18,'h18,'h18,'h18,'h18,'h1E,'h00},
      '{'h08,'h1C,'h36,'h63,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'hFF},
      '{'h0C,'h0C,'h18,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h1E,'h30,'h3E,'h33,'h6E,'h00},
      '{'h07,'h06,'h06,'h3E,'h66,'h66,'h3B,'h00},
      '{'h00,'h00,'h1E,'h33,'h03,'h33,'h1E,'h00},
      '{'h38,'h30,'h30,'h3E,'h33,'h33,'h6E,'h00},
      '{'h00,'h00,'h1E,'h33,'h3F,'h03,'h1E,'h00},
      '{'h1C,'h36,'h06,'h0F,'h06,'h06,'h0F,'h00},
      '{'h00,'h00,'h6E,'h33,'h33,'h3E,'h30,'h1F},
      '{'h07,'h06,'h36,'h6E,'h66,'h66,'h67,'h00},
      '{'h0C,'h00,'h0E,'h0C,'h0C,'h0C,'h1E,'h00},
      '{'h30,'h00,'h30,'h30,'h30,'h33,'h33,'h1E},
      '{'h07,'h06,'h66,'h36,'h1E,'h36,'h67,'h00},
      '{'h0E,'h0C,'h0C,'h0C,'h0C,'h0C,'h1E,'h00},
      '{'h00,'h00,'h33,'h7F,'h7F,'h6B,'h63,'h00},
      '{'h00,'h00,'h1F,'h33,'h33,'h33,'h33,'h00},
      '{'h00,'h00,'h1E,'h33,'h33,'h33,'h1E,'h00},
      '{'h00,'h00,'h3B,'h66,'h66,'h3E,'h06,'h0F},
      '{'h00,'h00,'h6E,'h33,'h33,'h3E,'h30,'h78},
      '{'h00,'h00,'h3B,'h6E,'h66,'h06,'h0F,'h00},
      '{'h00,'h00,'h3E,'h03,'h1E,'h30,'h1F,'h00},
      '{'h08,'h0C,'h3E,'h0C,'h0C,'h2C,'h18,'h00},
      '{'h00,'h00,'h33,'h33,'h33,'h33,'h6E,'h00},
      '{'h00,'h00,'h33,'h33,'h33,'h1E,'h0C,'h00},
      '{'h00,'h00,'h63,'h6B,'h7F,'h7F,'h36,'h00},
      '{'h00,'h00,'h63,'h36,'h1C,'h36,'h63,'h00},
      '{'h00,'h00,'h33,'h33,'h33,'h3E,'h30,'h1F},
      '{'h00,'h00,'h3F,'h19,'h0C,'h26,'h3F,'h00},
      '{'h38,'h0C,'h0C,'h07,'h0C,'h0C,'h38,'h00},
      '{'h18,'h18,'h18,'h00,'h18,'h18,'h18,'h00},
      '{'h07,'h0C,'h0C,'h38,'h0C,'h0C,'h07,'h00},
      '{'h6E,'h3B,'h00,'h00,'h00,'h00,'h00,'h00},
      '{'h00,'h00,'h00,'h00,'h00,'h00,'h00,'h00}
   };

endpackage

@@ rtl/g8pp_glyph_rom.sv @@
// Font ROM with a registered read port: one glyph row per cycle.
module g8pp_glyph_rom #(
   parameter int GLYPH_COUNT = g8pp_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic clock,
   input  logic [g8pp_pkg::CODE_WIDTH-1:0] code,
   input  logic [g8pp_pkg::ROW_WIDTH-1:0] row,
   output g8pp_pkg::font_row_type row_bits
);
   import g8pp_pkg::*;

   logic glyph_present;
   font_row_type row_bits_ff;

   assign glyph_present = (int'(code) < GLYPH_COUNT);

   // codes at or above the glyph count read as blank
   always_ff @(posedge clock) begin
      row_bits_ff <= glyph_present ? FONT_ROM[code][row] : '0;
   end

   assign row_bits = row_bits_ff;

endmodule

@@ rtl/glyph_8x8_pixel_plotter_unit.sv @@
// Top level of the 8x8 glyph pixel plotter.
//
// Input channel req_*: one item per character (code, signed origin, ink).
// Result channel rsp_*: one pixel write item per visible set glyph pixel, in
// row then column order; the final item of a character has last_of_glyph set.
// A character with no visible pixel gives one item with is_write clear.
// Configuration csr_*: write enable, register index and data; write only
// while the block is idle.
//
// One character at a time: req_ready is high only when idle. A character
// goes through setup (origin row times pitch, then base add and first ROM
// read), a scan of the 64 glyph pixels (one glyph pixel per cycle from the
// registered font ROM while the scan does not stall) and a flush that hands
// on the final item. The result register holds while rsp_ready is low; the
// scan stalls only when a second visible pixel would need the occupied
// result register.
// Reset (synchronous) restores register defaults and returns to idle.
module glyph_8x8_pixel_plotter_unit #(
   parameter int GLYPH_COUNT = g8pp_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  g8pp_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output g8pp_pkg::rsp_payload_type rsp_payload,
   input  logic csr_write_enable,
   input  logic [g8pp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [g8pp_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   import g8pp_pkg::*;

   `include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PREP = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [12:0] dest_width_ff, dest_height_ff;
   logic [13:0] line_pitch_ff;
   logic [31:0] frame_base_ff;

   logic [CODE_WIDTH-1:0] code_ff;
   logic signed [15:0] origin_x_ff, origin_y_ff;
   logic [7:0] ink_ff;
   logic [31:0] row_off_ff;
   logic [31:0] row_addr_ff, row_addr_in;
   logic [ROW_WIDTH-1:0] row_ff, row_in;
   logic [ROW_WIDTH-1:0] col_ff, col_in;
   logic pend_valid_ff, pend_valid_in;
   logic [31:0] pend_addr_ff, pend_addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic signed [30:0] row_off_full;
   font_row_type row_bits;
   logic [16:0] py, px;
   logic row_inside, col_inside, visible;
   logic can_push, push, advance;
   logic [31:0] pixel_addr;

   g8pp_glyph_rom #(
      .GLYPH_COUNT(GLYPH_COUNT)
   ) u_rom (
      .clock(clock),
      .code(code_ff),
      .row(row_in),
      .row_bits(row_bits)
   );

   assign row_off_full = $signed(req_payload.origin_y) * $signed({1'b0, line_pitch_ff});

   assign py = {origin_y_ff[15], origin_y_ff} + {14'd0, row_ff};
   assign px = {origin_x_ff[15], origin_x_ff} + {14'd0, col_ff};
   assign row_inside = !py[16] && (py[15:0] < {3'd0, dest_height_ff});
   assign col_inside = !px[16] && (px[15:0] < {3'd0, dest_width_ff});
   assign visible = row_bits[col_ff] && row_inside && col_inside;
   assign pixel_addr = row_addr_ff + {{15{px[16]}}, px};

   assign can_push = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      row_in = row_ff;
      col_in = col_ff;
      row_addr_in = row_addr_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in = pend_addr_ff;
      rsp_in = rsp_ff;
      push = 1'b0;
      advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            row_in = '0;
            col_in = '0;
            pend_valid_in = 1'b0;
            if (req_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            row_addr_in = frame_base_ff + row_off_ff;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            advance = !(visible && pend_valid_ff) || can_push;
            if (advance) begin
               if (visible) begin
                  // hand the older pixel on; the new one waits as pending
                  if (pend_valid_ff) begin
                     push = 1'b1;
                     rsp_in = '{pixel_address: pend_addr_ff, pixel_value: ink_ff,
                                is_write: 1'b1, last_of_glyph: 1'b0};
                  end
                  pend_valid_in = 1'b1;
                  pend_addr_in = pixel_addr;
               end
               col_in = col_ff + 1'b1;
               if (col_ff == ROW_WIDTH'(GLYPH_SIZE - 1)) begin
                  row_in = row_ff + 1'b1;
                  row_addr_in = row_addr_ff + {18'd0, line_pitch_ff};
                  if (row_ff == ROW_WIDTH'(GLYPH_SIZE - 1)) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (can_push) begin
               push = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = '{pixel_address: pend_addr_ff, pixel_value: ink_ff,
                             is_write: 1'b1, last_of_glyph: 1'b1};
               end else begin
                  rsp_in = '{pixel_address: '0, pixel_value: '0,
                             is_write: 1'b0, last_of_glyph: 1'b1};
               end
               pend_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_ff <= '0;
         col_ff <= '0;
         dest_width_ff <= DEST_WIDTH_RESET;
         dest_height_ff <= DEST_HEIGHT_RESET;
         line_pitch_ff <= LINE_PITCH_RESET;
         frame_base_ff <= FRAME_BASE_RESET;
      end else begin
         state_ff <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEST_WIDTH: dest_width_ff <= csr_write_data[12:0];
               CSR_DEST_HEIGHT: dest_height_ff <= csr_write_data[12:0];
               CSR_LINE_PITCH: line_pitch_ff <= csr_write_data[13:0];
               CSR_FRAME_BASE: frame_base_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         code_ff <= req_payload.char_code;
         origin_x_ff <= req_payload.origin_x;
         origin_y_ff <= req_payload.origin_y;
         ink_ff <= req_payload.ink;
         row_off_ff <= 32'(row_off_full);
      end
      row_addr_ff <= row_addr_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_IMPLIES(a_idle_no_pending, req_ready, !pend_valid_ff)
   `ASSERT_IMPLIES(a_placeholder_is_last, rsp_valid && !rsp_payload.is_write,
                   rsp_payload.last_of_glyph)
   `ASSERT_NEXT(a_accept_starts_setup, req_valid && req_ready, state_ff == ST_PREP)
   `ASSERT_NEXT(a_stalled_result_holds, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_payload))

endmodule
